### rtl/core/gapw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapw_pkg: shared constants for the replay window
// Field widths, command codes and the millisecond scale used by the
// retention check.
// ----------------------------------------------------------------------------
package gapw_pkg;

  localparam int PTS_W    = 48;   // timestamp width, two's complement ms
  localparam int WIN_W    = 16;   // window register width, whole seconds
  localparam int HDL_W    = 16;   // handle width on the channel
  localparam int OFS_W    = 6;    // read offset width
  localparam int CNT_W    = 7;    // evicted count and occupancy width
  localparam int MS_PER_S = 1000;

  // Largest threshold is (65535 + 1) * 1000, which needs 26 bits.
  localparam int THR_W = 27;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd10;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

endpackage

### rtl/core/gapw_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapw_in_if: command channel of the replay window
// Valid/ready channel that carries one append or read command per item.
// ----------------------------------------------------------------------------
interface gapw_in_if;
  import gapw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [PTS_W-1:0] pkt_pts;
  logic                    pkt_key;
  logic [HDL_W-1:0]        pkt_handle;
  logic [OFS_W-1:0]        read_offset;

  modport source (
    output valid, cmd, pkt_pts, pkt_key, pkt_handle, read_offset,
    input  ready
  );

  modport sink (
    input  valid, cmd, pkt_pts, pkt_key, pkt_handle, read_offset,
    output ready
  );

endinterface

### rtl/core/gapw_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapw_out_if: result channel of the replay window
// Valid/ready channel that carries one result item per command.
// ----------------------------------------------------------------------------
interface gapw_out_if;
  import gapw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CNT_W-1:0]        evicted_count;
  logic [CNT_W-1:0]        occupancy;
  logic                    overflow;
  logic                    entry_valid;
  logic signed [PTS_W-1:0] entry_pts;
  logic                    entry_key;
  logic [HDL_W-1:0]        entry_handle;

  modport source (
    output valid, evicted_count, occupancy, overflow, entry_valid,
           entry_pts, entry_key, entry_handle,
    input  ready
  );

  modport sink (
    input  valid, evicted_count, occupancy, overflow, entry_valid,
           entry_pts, entry_key, entry_handle,
    output ready
  );

endinterface

### rtl/core/gapw_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapw_ring_mem: descriptor storage
// Simple dual-port ring memory, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module gapw_ring_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/gapw_span_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapw_span_cmp: retention span comparator
// Decides whether the newest minus the oldest timestamp, truncated to whole
// seconds, is past the window.
// ----------------------------------------------------------------------------
module gapw_span_cmp
  import gapw_pkg::*;
(
  input  logic signed [PTS_W-1:0] newest_pts,
  input  logic signed [PTS_W-1:0] oldest_pts,
  input  logic [THR_W-1:0]        thr_ms,
  output logic                    exceeded
);

  logic [PTS_W:0] diff;

  // For a positive span, trunc(d / 1000) > W holds exactly when
  // d >= 1000 * (W + 1); a zero or negative span never exceeds the window.
  assign diff     = {newest_pts[PTS_W-1], newest_pts} - {oldest_pts[PTS_W-1], oldest_pts};
  assign exceeded = !diff[PTS_W] && (diff[PTS_W-1:0] >= PTS_W'(thr_ms));

endmodule

### rtl/core/gap_aligned_top_placeholder_never_used.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapw_ofs_slot: ring slot of an offset
// Maps an offset from the oldest entry to its ring slot, wrapping once.
// ----------------------------------------------------------------------------
module gapw_ofs_slot #(
  parameter int DEPTH = 64
) (
  input  logic [$clog2(DEPTH)-1:0] head,
  input  logic [gapw_pkg::OFS_W-1:0] offset,
  output logic [$clog2(DEPTH)-1:0] slot
);
  import gapw_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = ((AW > OFS_W) ? AW : OFS_W) + 1;

  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;

  // Only offsets below the occupancy are used, so the sum stays below
  // twice the depth and one subtract wraps it.
  assign sum     = SW'(head) + SW'(offset);
  assign wrapped = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
  assign slot    = wrapped[AW-1:0];

endmodule

### rtl/core/gop_aligned_replay_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gop_aligned_replay_window: ring of packet descriptors with GOP eviction
// Appends packet descriptors, drops whole groups of pictures from the front
// once the held span passes the window, and reads entries by offset.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH descriptors (timestamp, key flag, handle) in a
// ring memory with one registered read port, and handles one command item at
// a time; in_ch.ready is high only while the sequencer is idle and reset is
// released. An append with nothing evicted steps through accept, store the
// packet, fetch the oldest timestamp and compare the span. Every evicted
// group drops its first entry, then reads and checks each further entry and
// the key-flag probe that ends a group while entries remain; each window check
// after a group fetches and compares again, and all of these steps go through
// the single memory read port. A result waits in an output register,
// so the next command is taken while it is still pending; the sequencer only
// stalls in its last step if the previous result has not been taken yet. The
// window compare is a single subtract-and-compare against a threshold of
// 1000 * (window_seconds + 1) ms, which is formed when the register is
// written. Store entries need no reset: reads are gated by occupancy.
// ----------------------------------------------------------------------------
module gop_aligned_replay_window #(
  parameter int DEPTH        = 64,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gapw_in_if.sink                    in_ch,
  gapw_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [gapw_pkg::WIN_W-1:0] cfg_wdata
);
  import gapw_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int HW = HANDLE_WIDTH;
  localparam int DW = PTS_W + 1 + HW;

  // Sequencer codes.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EV_DROP = 3'd1;
  localparam logic [2:0] S_EV_RD   = 3'd2;
  localparam logic [2:0] S_EV_CHK  = 3'd3;
  localparam logic [2:0] S_WR      = 3'd4;
  localparam logic [2:0] S_WIN_RD  = 3'd5;
  localparam logic [2:0] S_WIN_CMP = 3'd6;
  localparam logic [2:0] S_RD_DONE = 3'd7;

  // Control state.
  logic [2:0]     state_r,   state_nxt;
  logic [AW-1:0]  head_r,    head_nxt;
  logic [CW-1:0]  count_r,   count_nxt;
  logic [CW-1:0]  ev_r,      ev_nxt;
  logic           ovf_r,     ovf_nxt;
  logic           ret_wr_r,  ret_wr_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic [THR_W-1:0] thr_r,   thr_nxt;

  // Payload held for the duration of one command.
  logic signed [PTS_W-1:0] pts_in_r,   pts_in_nxt;
  logic                    key_in_r,   key_in_nxt;
  logic [HW-1:0]           hdl_in_r,   hdl_in_nxt;
  logic signed [PTS_W-1:0] last_pts_r, last_pts_nxt;
  logic [AW-1:0]           slot_r,     slot_nxt;
  logic                    hit_r,      hit_nxt;

  // Result register.
  logic [CW-1:0]           res_ev_r,   res_ev_nxt;
  logic [CW-1:0]           res_occ_r,  res_occ_nxt;
  logic                    res_ovf_r,  res_ovf_nxt;
  logic                    res_vld_r,  res_vld_nxt;
  logic signed [PTS_W-1:0] res_pts_r,  res_pts_nxt;
  logic                    res_key_r,  res_key_nxt;
  logic [HW-1:0]           res_hdl_r,  res_hdl_nxt;

  logic [AW-1:0]           slot_in;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           tail;
  logic [CW:0]             tail_sum;
  logic                    mem_we;
  logic [DW-1:0]           rdata;
  logic signed [PTS_W-1:0] rd_pts;
  logic                    rd_key;
  logic [HW-1:0]           rd_hdl;
  logic                    exceeded;
  logic                    out_free;
  logic                    accept;
  logic [AW-1:0]           head_inc;
  logic                    grp_last;
  logic [2:0]              grp_ret;
  logic [31:0]             hdl_in_ext;
  logic [31:0]             ev_ext;
  logic [31:0]             occ_ext;
  logic [31:0]             hdl_out_ext;

  // ---------------------------------------------------------------- datapath
  gapw_ofs_slot #(.DEPTH(DEPTH)) u_slot (
    .head   (head_r),
    .offset (in_ch.read_offset),
    .slot   (slot_in)
  );

  // The tail slot is head + count; count stays below DEPTH when written.
  assign tail_sum = (CW + 1)'(head_r) + (CW + 1)'(count_r);
  assign tail     = (tail_sum >= (CW + 1)'(DEPTH)) ? AW'(tail_sum - (CW + 1)'(DEPTH))
                                                   : AW'(tail_sum);

  always_comb begin
    case (state_r)
      S_IDLE:    raddr = slot_in;
      S_RD_DONE: raddr = slot_r;
      default:   raddr = head_r;
    endcase
  end

  assign mem_we = (state_r == S_WR);

  gapw_ring_mem #(.DEPTH(DEPTH), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail),
    .wdata ({pts_in_r, key_in_r, hdl_in_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_pts = rdata[DW-1 -: PTS_W];
  assign rd_key = rdata[HW];
  assign rd_hdl = rdata[HW-1:0];

  gapw_span_cmp u_cmp (
    .newest_pts (last_pts_r),
    .oldest_pts (rd_pts),
    .thr_ms     (thr_r),
    .exceeded   (exceeded)
  );

  assign head_inc   = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign grp_last   = (count_r == CW'(1));
  assign grp_ret    = ret_wr_r ? S_WR : S_WIN_RD;
  assign out_free   = !out_vld_r || out_ch.ready;
  assign accept     = in_ch.valid && in_ch.ready;
  assign hdl_in_ext = 32'(in_ch.pkt_handle);
  assign thr_nxt    = cfg_we ? THR_W'((32'(cfg_wdata) + 32'd1) * MS_PER_S) : thr_r;

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    ev_nxt       = ev_r;
    ovf_nxt      = ovf_r;
    ret_wr_nxt   = ret_wr_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    pts_in_nxt   = pts_in_r;
    key_in_nxt   = key_in_r;
    hdl_in_nxt   = hdl_in_r;
    last_pts_nxt = last_pts_r;
    slot_nxt     = slot_r;
    hit_nxt      = hit_r;
    res_ev_nxt   = res_ev_r;
    res_occ_nxt  = res_occ_r;
    res_ovf_nxt  = res_ovf_r;
    res_vld_nxt  = res_vld_r;
    res_pts_nxt  = res_pts_r;
    res_key_nxt  = res_key_r;
    res_hdl_nxt  = res_hdl_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ev_nxt     = '0;
          ovf_nxt    = 1'b0;
          pts_in_nxt = in_ch.pkt_pts;
          key_in_nxt = in_ch.pkt_key;
          hdl_in_nxt = hdl_in_ext[HW-1:0];
          slot_nxt   = slot_in;
          hit_nxt    = (32'(in_ch.read_offset) < 32'(count_r));
          if (in_ch.cmd == CMD_READ) begin
            state_nxt = S_RD_DONE;
          end else if (count_r == CW'(DEPTH)) begin
            // Full ring: one group goes first, then the packet is stored.
            ovf_nxt    = 1'b1;
            ret_wr_nxt = 1'b1;
            state_nxt  = S_EV_DROP;
          end else begin
            state_nxt = S_WR;
          end
        end
      end
      S_EV_DROP: begin
        head_nxt  = head_inc;
        count_nxt = count_r - CW'(1);
        ev_nxt    = ev_r + CW'(1);
        state_nxt = grp_last ? grp_ret : S_EV_RD;
      end
      S_EV_RD: begin
        state_nxt = S_EV_CHK;
      end
      S_EV_CHK: begin
        // The group runs up to, but not including, the next key packet.
        if (!rd_key) begin
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
          ev_nxt    = ev_r + CW'(1);
          state_nxt = grp_last ? grp_ret : S_EV_RD;
        end else begin
          state_nxt = grp_ret;
        end
      end
      S_WR: begin
        count_nxt    = count_r + CW'(1);
        last_pts_nxt = pts_in_r;
        ret_wr_nxt   = 1'b0;
        state_nxt    = S_WIN_RD;
      end
      S_WIN_RD: begin
        state_nxt = S_WIN_CMP;
      end
      S_WIN_CMP: begin
        if ((count_r != '0) && exceeded) begin
          state_nxt = S_EV_DROP;
        end else if (out_free) begin
          out_vld_nxt = 1'b1;
          res_ev_nxt  = ev_r;
          res_occ_nxt = count_r;
          res_ovf_nxt = ovf_r;
          res_vld_nxt = 1'b0;
          res_pts_nxt = '0;
          res_key_nxt = 1'b0;
          res_hdl_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_RD_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          res_ev_nxt  = '0;
          res_occ_nxt = count_r;
          res_ovf_nxt = 1'b0;
          res_vld_nxt = hit_r;
          res_pts_nxt = hit_r ? rd_pts : '0;
          res_key_nxt = hit_r && rd_key;
          res_hdl_nxt = hit_r ? rd_hdl : '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      ev_r      <= '0;
      ovf_r     <= 1'b0;
      ret_wr_r  <= 1'b0;
      out_vld_r <= 1'b0;
      thr_r     <= THR_W'((32'(WIN_RESET) + 32'd1) * MS_PER_S);
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      ev_r      <= ev_nxt;
      ovf_r     <= ovf_nxt;
      ret_wr_r  <= ret_wr_nxt;
      out_vld_r <= out_vld_nxt;
      thr_r     <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pts_in_r   <= pts_in_nxt;
    key_in_r   <= key_in_nxt;
    hdl_in_r   <= hdl_in_nxt;
    last_pts_r <= last_pts_nxt;
    slot_r     <= slot_nxt;
    hit_r      <= hit_nxt;
    res_ev_r   <= res_ev_nxt;
    res_occ_r  <= res_occ_nxt;
    res_ovf_r  <= res_ovf_nxt;
    res_vld_r  <= res_vld_nxt;
    res_pts_r  <= res_pts_nxt;
    res_key_r  <= res_key_nxt;
    res_hdl_r  <= res_hdl_nxt;
  end

  // ------------------------------------------------------------------- ports
  // No item is taken while reset is held.
  assign in_ch.ready = (state_r == S_IDLE) && rst_n;

  assign ev_ext      = 32'(res_ev_r);
  assign occ_ext     = 32'(res_occ_r);
  assign hdl_out_ext = 32'(res_hdl_r);

  assign out_ch.valid         = out_vld_r;
  assign out_ch.evicted_count = ev_ext[CNT_W-1:0];
  assign out_ch.occupancy     = occ_ext[CNT_W-1:0];
  assign out_ch.overflow      = res_ovf_r;
  assign out_ch.entry_valid   = res_vld_r;
  assign out_ch.entry_pts     = res_pts_r;
  assign out_ch.entry_key     = res_key_r;
  assign out_ch.entry_handle  = hdl_out_ext[HDL_W-1:0];

  // -------------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above ring depth");

  a_idle_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> (head_r == $past(head_r)))
    else $error("ring head moved without a command in progress");

  a_ovf_evicts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_ovf_r) |-> (res_ev_r != '0))
    else $error("overflow reported without an eviction");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_vld_r) |-> ((res_ev_r == '0) && !res_ovf_r))
    else $error("read result carries eviction status");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (count_r < CW'(DEPTH)))
    else $error("packet store started on a full ring");

endmodule
